[src/rnm_pkg.sv]
package rnm_pkg;

  localparam logic [1:0] OP_PAT_WR = 2'd0;
  localparam logic [1:0] OP_TEXT   = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_INIT,
    ST_B_STEP,
    ST_CLOSURE,
    ST_DISPATCH,
    ST_SPREAD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic pat_wr;
    logic cap;
    logic b_init;
    logic b_pop;
    logic b_step;
    logic b_finish;
    logic clo_step;
    logic move;
    logic start;
    logic spread;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic pop_bar;
    logic k_last;
    logic last;
    logic op_empty;
  } sts_t;

  function automatic logic is_meta(input logic [7:0] c);
    return (c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_BAR) ||
           (c == CH_STAR) || (c == CH_DOT);
  endfunction

endpackage

[src/rnm_ctrl.sv]
module rnm_ctrl
  import rnm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  input  logic       out_stall,
  input  logic       cfg_wr_en,
  input  sts_t       sts,
  output logic       in_stall,
  output logic       out_valid,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   stale_r, stale_nxt;
  logic   in_text_r, in_text_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stale_r     <= 1'b1;
      in_text_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stale_r     <= stale_nxt;
      in_text_r   <= in_text_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stale_nxt     = stale_r;
    in_text_nxt   = in_text_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    if (cfg_wr_en) begin
      stale_nxt   = 1'b1;
      in_text_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_operation == OP_PAT_WR) begin
            cmd.pat_wr  = 1'b1;
            stale_nxt   = 1'b1;
            in_text_nxt = 1'b0;
          end else if (in_operation == OP_TEXT || in_operation == OP_EMPTY) begin
            cmd.cap   = 1'b1;
            state_nxt = stale_r ? ST_B_INIT : ST_DISPATCH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_B_INIT: begin
        cmd.b_init = 1'b1;
        state_nxt  = ST_B_STEP;
      end
      ST_B_STEP: begin
        priority if (sts.i_done) begin
          cmd.b_finish = 1'b1;
          state_nxt    = ST_CLOSURE;
        end else if (sts.pop_bar) begin
          cmd.b_pop = 1'b1;
        end else begin
          cmd.b_step = 1'b1;
        end
      end
      ST_CLOSURE: begin
        cmd.clo_step = 1'b1;
        if (sts.k_last) begin
          stale_nxt = 1'b0;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.op_empty) begin
          in_text_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.move  = 1'b1;
          cmd.start = !in_text_r;
          state_nxt = ST_SPREAD;
        end
      end
      ST_SPREAD: begin
        cmd.spread = 1'b1;
        if (sts.last) begin
          in_text_nxt = 1'b0;
          state_nxt   = ST_RESULT;
        end else begin
          in_text_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_graph_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DISPATCH) |-> !stale_r)
    else $error("query evaluated on a stale graph");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.b_init, cmd.b_pop, cmd.b_step, cmd.b_finish, cmd.clo_step,
              cmd.move, cmd.spread}))
    else $error("conflicting datapath commands");

endmodule

[src/rnm_dp.sv]
module rnm_dp
  import rnm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [1:0] in_operation,
  input  logic [4:0] in_index,
  input  logic [7:0] in_character,
  input  logic       in_last,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  output sts_t       sts,
  output logic       out_matched,
  output logic       out_bad_pattern
);

  localparam int NV = MAX_PATTERN + 1;
  localparam int CW = $clog2(NV);
  localparam int PW = $clog2(MAX_PATTERN);

  logic [7:0]    pat_r [MAX_PATTERN];
  logic [NV-1:0] reach_r [NV];
  logic [NV-1:0] reach_nxt [NV];
  logic [NV-1:0] act_r, moved_r, barmask_r;
  logic [PW-1:0] stk_pos_r [MAX_PATTERN];
  logic          stk_bar_r [MAX_PATTERN];
  logic [CW-1:0] cnt_r, sp_r, opens_r;
  logic [5:0]    len_r;
  logic          err_r, op_empty_r, last_r;
  logic [7:0]    ch_r;
  logic          out_matched_r, out_bad_r;

  logic [NV-1:0] c_open, c_close, c_bar, c_star, c_dot, lit;
  logic [CW-1:0] n, lp, o_p1;
  logic [CW:0]   ip1;
  logic          nv, op_i, cl_i, bar_i, st_i, dot_i, nx_st, nx_dot, have_top;
  logic [PW-1:0] top_idx, top_pos;
  logic [NV-1:0] oh_i, oh_i1, oh_lp, oh_o1, add_lp, add_i, add_i1, krow, act_cur;
  logic [NV-1:0] moved_nxt, spread_nxt;
  logic          star_link;

  assign n = (32'(len_r) > MAX_PATTERN) ? CW'(MAX_PATTERN) : CW'(len_r);

  always_comb begin
    for (int s = 0; s < NV; s++) begin
      if (s < MAX_PATTERN) begin
        c_open[s]  = (pat_r[s] == CH_OPEN);
        c_close[s] = (pat_r[s] == CH_CLOSE);
        c_bar[s]   = (pat_r[s] == CH_BAR);
        c_star[s]  = (pat_r[s] == CH_STAR);
        c_dot[s]   = (pat_r[s] == CH_DOT);
        lit[s]     = !is_meta(pat_r[s]) && (CW'(s) < n);
      end else begin
        c_open[s]  = 1'b0;
        c_close[s] = 1'b0;
        c_bar[s]   = 1'b0;
        c_star[s]  = 1'b0;
        c_dot[s]   = 1'b0;
        lit[s]     = 1'b0;
      end
    end
  end

  assign ip1      = {1'b0, cnt_r} + 1'b1;
  assign nv       = ip1 < {1'b0, n};
  assign op_i     = c_open[cnt_r];
  assign cl_i     = c_close[cnt_r];
  assign bar_i    = c_bar[cnt_r];
  assign st_i     = c_star[cnt_r];
  assign dot_i    = c_dot[cnt_r];
  assign nx_st    = nv && c_star[ip1[CW-1:0]];
  assign nx_dot   = nv && c_dot[ip1[CW-1:0]];
  assign have_top = (sp_r != '0);
  assign top_idx  = PW'(sp_r - 1'b1);
  assign top_pos  = stk_pos_r[top_idx];
  assign lp       = have_top ? CW'(top_pos) : cnt_r;
  assign o_p1     = CW'(top_pos) + 1'b1;
  assign oh_i     = NV'(1) << cnt_r;
  assign oh_i1    = NV'(1) << ip1[CW-1:0];
  assign oh_lp    = NV'(1) << lp;
  assign oh_o1    = NV'(1) << o_p1;
  assign star_link = nx_st && !(cl_i || st_i || op_i);
  assign krow     = reach_r[cnt_r];

  always_comb begin
    add_lp = '0;
    add_i  = '0;
    add_i1 = '0;
    if (cl_i) begin
      if (have_top) add_lp = add_lp | barmask_r;
      if (nx_st || nx_dot) add_lp = add_lp | oh_i1;
      if (nx_st) add_i1 = add_i1 | oh_lp;
    end
    if (star_link || op_i || st_i || cl_i || dot_i) add_i = oh_i1;
    if (star_link) add_i1 = add_i1 | oh_i;
  end

  always_comb begin
    for (int r = 0; r < NV; r++) begin
      reach_nxt[r] = reach_r[r];
      priority if (cmd.b_init) begin
        reach_nxt[r] = NV'(1) << r;
      end else if (cmd.b_pop) begin
        if (CW'(r) == CW'(top_pos)) reach_nxt[r] = reach_r[r] | oh_i;
      end else if (cmd.b_step) begin
        if (cl_i && CW'(r) == lp) reach_nxt[r] = reach_nxt[r] | add_lp;
        if (CW'(r) == cnt_r) reach_nxt[r] = reach_nxt[r] | add_i;
        if ({1'b0, CW'(r)} == ip1) reach_nxt[r] = reach_nxt[r] | add_i1;
      end else if (cmd.clo_step) begin
        if (reach_r[r][cnt_r]) reach_nxt[r] = reach_r[r] | krow;
      end else begin
        reach_nxt[r] = reach_r[r];
      end
    end
  end

  assign act_cur = cmd.start ? reach_r[0] : act_r;

  always_comb begin
    moved_nxt = '0;
    for (int s = 0; s < MAX_PATTERN; s++) begin
      moved_nxt[s+1] = act_cur[s] && lit[s] && (pat_r[s] == ch_r);
    end
    spread_nxt = '0;
    for (int s = 0; s < NV; s++) begin
      if (moved_r[s]) spread_nxt = spread_nxt | reach_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      cnt_r   <= '0;
      sp_r    <= '0;
      opens_r <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) len_r <= cfg_wr_data;
      if (cmd.b_init) begin
        cnt_r   <= '0;
        sp_r    <= '0;
        opens_r <= '0;
        err_r   <= 1'b0;
      end else if (cmd.b_pop) begin
        sp_r <= sp_r - 1'b1;
      end else if (cmd.b_step) begin
        cnt_r <= cnt_r + 1'b1;
        if (op_i || bar_i) begin
          sp_r <= sp_r + 1'b1;
          if (op_i) opens_r <= opens_r + 1'b1;
        end
        if (cl_i) begin
          if (have_top) begin
            sp_r    <= sp_r - 1'b1;
            opens_r <= opens_r - 1'b1;
          end else begin
            err_r <= 1'b1;
          end
        end
      end else if (cmd.b_finish) begin
        cnt_r <= '0;
        if (opens_r != '0) err_r <= 1'b1;
      end else if (cmd.clo_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pat_wr && (32'(in_index) < MAX_PATTERN)) pat_r[PW'(in_index)] <= in_character;
    for (int r = 0; r < NV; r++) reach_r[r] <= reach_nxt[r];
    if (cmd.b_init) barmask_r <= '0;
    else if (cmd.b_pop) barmask_r <= barmask_r | oh_o1;
    else if (cmd.b_step && cl_i) barmask_r <= '0;
    if (cmd.b_step && (op_i || bar_i)) begin
      stk_pos_r[PW'(sp_r)] <= PW'(cnt_r);
      stk_bar_r[PW'(sp_r)] <= bar_i;
    end
    if (cmd.cap) begin
      op_empty_r <= (in_operation == OP_EMPTY);
      ch_r       <= in_character;
      last_r     <= in_last;
    end
    if (cmd.move) moved_r <= moved_nxt;
    if (cmd.spread) act_r <= spread_nxt;
    if (cmd.load_out) begin
      out_matched_r <= op_empty_r ? reach_r[0][n] : act_r[n];
      out_bad_r     <= err_r;
    end
  end

  assign sts.i_done   = (cnt_r >= n);
  assign sts.pop_bar  = cl_i && have_top && stk_bar_r[top_idx];
  assign sts.k_last   = (cnt_r == CW'(MAX_PATTERN));
  assign sts.last     = last_r;
  assign sts.op_empty = op_empty_r;

  assign out_matched     = out_matched_r;
  assign out_bad_pattern = out_bad_r;

endmodule

[src/regex_nfa_matcher.sv]
// Regular expression matcher over an automaton with epsilon edges. Pattern bytes are written
// by position (operation 0, each taken while the block stays idle) and the length through the cfg
// port; the operators are ( ) | * with '.' as explicit concatenation. The first text or
// empty-text request after a pattern or length change first builds the graph: an init step, one
// step per pattern position plus one per bar closed by ')', and a finish step walk the pattern,
// then the closure takes pivot rows 0 to MAX_PATTERN, one pivot row per cycle. After that a
// text byte is captured, moved and spread over the stored closure rows; the byte marked last
// then loads the result; an empty-text request is captured, dispatched and loads the result.
// A result still held by out_stall delays that load, and the input stays stalled until done.
module regex_nfa_matcher
  import rnm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [4:0] in_index,
  input  logic [7:0] in_character,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_matched,
  output logic       out_bad_pattern
);

  cmd_t cmd;
  sts_t sts;

  rnm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_stall    (out_stall),
    .cfg_wr_en    (cfg_wr_en),
    .sts          (sts),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  rnm_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_index        (in_index),
    .in_character    (in_character),
    .in_last         (in_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .sts             (sts),
    .out_matched     (out_matched),
    .out_bad_pattern (out_bad_pattern)
  );

endmodule
